// ----- hdl/arm_data_processing_executor_macros.svh -----
// ----------------------------------------------------------------------------
// arm_data_processing_executor_macros.svh
// Assertion macros for the data-processing executor.
// ----------------------------------------------------------------------------
`ifndef ARM_DATA_PROCESSING_EXECUTOR_MACROS_SVH
`define ARM_DATA_PROCESSING_EXECUTOR_MACROS_SVH

`ifndef SYNTHESIS
`define DPX_ASSERT_IMPL(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dpx assertion failed");
`define DPX_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dpx assertion failed");
`else
`define DPX_ASSERT_IMPL(name, cond, prop)
`define DPX_ASSERT_NEXT(name, cond, prop)
`endif

`endif

// ----- hdl/dpx_pkg.sv -----
// ----------------------------------------------------------------------------
// dpx_pkg
// Types, codes and helpers of the data-processing executor.
// ----------------------------------------------------------------------------
package dpx_pkg;

  typedef enum logic [1:0] {
    CMD_EXEC         = 2'd0,
    CMD_WRITE_REG    = 2'd1,
    CMD_WRITE_STATUS = 2'd2,
    CMD_WRITE_SAVED  = 2'd3
  } cmd_code_t;

  localparam logic [3:0] OP_AND = 4'h0;
  localparam logic [3:0] OP_EOR = 4'h1;
  localparam logic [3:0] OP_SUB = 4'h2;
  localparam logic [3:0] OP_RSB = 4'h3;
  localparam logic [3:0] OP_ADD = 4'h4;
  localparam logic [3:0] OP_ADC = 4'h5;
  localparam logic [3:0] OP_SBC = 4'h6;
  localparam logic [3:0] OP_RSC = 4'h7;
  localparam logic [3:0] OP_TST = 4'h8;
  localparam logic [3:0] OP_TEQ = 4'h9;
  localparam logic [3:0] OP_CMP = 4'hA;
  localparam logic [3:0] OP_CMN = 4'hB;
  localparam logic [3:0] OP_ORR = 4'hC;
  localparam logic [3:0] OP_MOV = 4'hD;
  localparam logic [3:0] OP_BIC = 4'hE;
  localparam logic [3:0] OP_MVN = 4'hF;

  localparam logic [3:0] COND_AL = 4'hE;

  localparam logic [4:0] MODE_FAST  = 5'h11;
  localparam logic [4:0] MODE_INTR  = 5'h12;
  localparam logic [4:0] MODE_SUPER = 5'h13;
  localparam logic [4:0] MODE_ABORT = 5'h17;
  localparam logic [4:0] MODE_UNDEF = 5'h1B;

  localparam int          NUM_BANKS = 5;
  localparam logic [3:0]  REG_LR    = 4'd14;
  localparam logic [3:0]  REG_PC    = 4'd15;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instruction;
    logic [3:0]  target_index;
    logic [31:0] write_value;
  } cmd_item_t;

  typedef struct packed {
    logic        executed;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        link_written;
    logic [31:0] link_value;
    logic [31:0] status_out;
  } res_item_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    logic [5:0] inv;
    inv = 6'd32 - {1'b0, s};
    return (s == 5'd0) ? v : ((v >> s) | (v << inv));
  endfunction

  function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] nzcv);
    logic n, z, c, v, p;
    n = nzcv[3];
    z = nzcv[2];
    c = nzcv[1];
    v = nzcv[0];
    unique case (cond)
      4'h0: p = z;
      4'h1: p = !z;
      4'h2: p = c;
      4'h3: p = !c;
      4'h4: p = n;
      4'h5: p = !n;
      4'h6: p = v;
      4'h7: p = !v;
      4'h8: p = c && !z;
      4'h9: p = !c || z;
      4'hA: p = (n == v);
      4'hB: p = (n != v);
      4'hC: p = !z && (n == v);
      4'hD: p = z || (n != v);
      COND_AL: p = 1'b1;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/arm_data_processing_executor.sv -----
// ----------------------------------------------------------------------------
// arm_data_processing_executor
// ARM data-processing and branch execute stage with barrel shifter, register
// file, status word and saved-status banks.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// cmd     | cmd_valid / cmd_stall  | cmd (command, instruction, index, value)
// res     | res_valid / res_stall  | res (flags, register write, link, status)
//
// One item per cycle unless the result stalls; hold, then result register.
// Shifter, ALU and state update sit in one pass between the hold register
// and the result register; the next item sees the updated state.
// Synchronous reset clears register file, status word and saved banks.
// A stalled result holds the hold register; cmd_stall rises only then.
`include "arm_data_processing_executor_macros.svh"

module arm_data_processing_executor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  dpx_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output dpx_pkg::res_item_t res
);
  import dpx_pkg::*;

  logic [31:0] rf [16];
  logic [31:0] status;
  logic [31:0] saved [NUM_BANKS];

  logic        hold_valid;
  cmd_item_t   hold;
  logic        advance;

  logic [31:0] w, rm, rn, op2, a, b, r, off;
  logic [7:0]  rs;
  logic [4:0]  imm, rsa, rot;
  logic        cin, sign, sc, ci, arith, vflag, cflag, pass;
  logic [32:0] sum;
  logic [3:0]  opc;

  logic        rf_we, lr_we, bank_we;
  logic [3:0]  rf_idx;
  logic [31:0] rf_val, status_next;
  res_item_t   res_next;

  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = hold_valid && !advance;

  always_comb begin
    w    = hold.instruction;
    rm   = rf[w[3:0]];
    rs   = rf[w[11:8]][7:0];
    rn   = rf[w[19:16]];
    cin  = status[29];
    sign = rm[31];
    imm  = w[11:7];
    rsa  = rs[4:0];
    rot  = {w[11:8], 1'b0};
    opc  = w[24:21];
    pass = cond_pass(w[31:28], status[31:28]);
    off  = {{6{w[23]}}, w[23:0], 2'b00};

    op2 = rm;
    sc  = cin;
    if (w[25]) begin
      op2 = ror32({24'd0, w[7:0]}, rot);
      sc  = (rot == 5'd0) ? cin : op2[31];
    end else begin
      unique case (w[6:4])
        3'd0: begin
          if (imm != 5'd0) begin
            op2 = rm << imm;
            sc  = rm[5'(6'd32 - {1'b0, imm})];
          end
        end
        3'd1: begin
          if (rs == 8'd0) begin
          end else if (rs < 8'd32) begin
            op2 = rm << rsa;
            sc  = rm[5'(6'd32 - {1'b0, rsa})];
          end else begin
            op2 = 32'd0;
            sc  = (rs == 8'd32) ? rm[0] : 1'b0;
          end
        end
        3'd2: begin
          if (imm == 5'd0) begin
            op2 = 32'd0;
            sc  = sign;
          end else begin
            op2 = rm >> imm;
            sc  = rm[imm - 5'd1];
          end
        end
        3'd3: begin
          if (rs == 8'd0) begin
          end else if (rs < 8'd32) begin
            op2 = rm >> rsa;
            sc  = rm[rsa - 5'd1];
          end else begin
            op2 = 32'd0;
            sc  = (rs == 8'd32) ? sign : 1'b0;
          end
        end
        3'd4: begin
          if (imm == 5'd0) begin
            op2 = {32{sign}};
            sc  = sign;
          end else begin
            op2 = $unsigned($signed(rm) >>> imm);
            sc  = rm[imm - 5'd1];
          end
        end
        3'd5: begin
          if (rs == 8'd0) begin
          end else if (rs < 8'd32) begin
            op2 = $unsigned($signed(rm) >>> rsa);
            sc  = rm[rsa - 5'd1];
          end else begin
            op2 = {32{sign}};
            sc  = sign;
          end
        end
        3'd6: begin
          if (imm == 5'd0) begin
            op2 = {cin, rm[31:1]};
            sc  = rm[0];
          end else begin
            op2 = ror32(rm, imm);
            sc  = rm[imm - 5'd1];
          end
        end
        default: begin
          if (rs == 8'd0) begin
          end else if (rsa == 5'd0) begin
            sc = sign;
          end else begin
            op2 = ror32(rm, rsa);
            sc  = rm[rsa - 5'd1];
          end
        end
      endcase
    end

    a     = rn;
    b     = op2;
    ci    = 1'b0;
    arith = 1'b1;
    unique case (opc)
      OP_SUB, OP_CMP: begin b = ~op2; ci = 1'b1; end
      OP_RSB:         begin a = op2; b = ~rn; ci = 1'b1; end
      OP_ADD, OP_CMN: begin end
      OP_ADC:         ci = cin;
      OP_SBC:         begin b = ~op2; ci = cin; end
      OP_RSC:         begin a = op2; b = ~rn; ci = cin; end
      default:        arith = 1'b0;
    endcase
    sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};

    unique case (opc)
      OP_AND, OP_TST: r = rn & op2;
      OP_EOR, OP_TEQ: r = rn ^ op2;
      OP_ORR:         r = rn | op2;
      OP_MOV:         r = op2;
      OP_BIC:         r = rn & ~op2;
      OP_MVN:         r = ~op2;
      default:        r = sum[31:0];
    endcase
    cflag = arith ? sum[32] : sc;
    vflag = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);

    rf_we       = 1'b0;
    lr_we       = 1'b0;
    bank_we     = 1'b0;
    rf_idx      = hold.target_index;
    rf_val      = hold.write_value;
    status_next = status;
    res_next    = '0;

    unique case (cmd_code_t'(hold.command))
      CMD_WRITE_REG:    rf_we = 1'b1;
      CMD_WRITE_STATUS: status_next = hold.write_value;
      CMD_WRITE_SAVED:  bank_we = (hold.target_index < 4'(NUM_BANKS));
      default: begin
        if (pass && w[27:26] == 2'b00) begin
          res_next.executed = 1'b1;
          if (opc[3:2] == 2'b10 || (w[20] && w[15:12] != REG_PC)) begin
            status_next[31] = r[31];
            status_next[30] = (r == 32'd0);
            status_next[29] = cflag;
            if (arith) status_next[28] = vflag;
          end else if (w[20]) begin
            priority case (status[4:0])
              MODE_FAST:  status_next = saved[0];
              MODE_INTR:  status_next = saved[1];
              MODE_SUPER: status_next = saved[2];
              MODE_ABORT: status_next = saved[3];
              MODE_UNDEF: status_next = saved[4];
              default:    status_next = status;
            endcase
          end
          if (opc[3:2] != 2'b10) begin
            rf_we                = 1'b1;
            rf_idx               = w[15:12];
            rf_val               = r;
            res_next.reg_written = 1'b1;
            res_next.reg_index   = w[15:12];
            res_next.reg_value   = r;
          end
        end else if (pass && w[27:25] == 3'b101) begin
          res_next.executed    = 1'b1;
          rf_we                = 1'b1;
          rf_idx               = REG_PC;
          rf_val               = rf[REG_PC] + off;
          res_next.reg_written = 1'b1;
          res_next.reg_index   = REG_PC;
          res_next.reg_value   = rf[REG_PC] + off;
          if (w[24]) begin
            lr_we                 = 1'b1;
            res_next.link_written = 1'b1;
            res_next.link_value   = rf[REG_PC] - 32'd4;
          end
        end
      end
    endcase
    res_next.status_out = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
      status     <= '0;
      for (int i = 0; i < 16; i++) rf[i] <= '0;
      for (int i = 0; i < NUM_BANKS; i++) saved[i] <= '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= hold_valid;
      end
      if (hold_valid && advance) begin
        status <= status_next;
        if (lr_we) rf[REG_LR] <= rf[REG_PC] - 32'd4;
        if (rf_we) rf[rf_idx] <= rf_val;
        if (bank_we) saved[hold.target_index[2:0]] <= hold.write_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) hold <= cmd;
    if (hold_valid && advance) res <= res_next;
  end

  `DPX_ASSERT_NEXT(a_hold_kept, hold_valid && !advance, hold_valid)
  `DPX_ASSERT_IMPL(a_link_pc, res_valid && res.link_written, res.reg_written && res.reg_index == REG_PC)
  `DPX_ASSERT_IMPL(a_no_exec_no_write, res_valid && !res.executed, !res.reg_written && !res.link_written)

endmodule
